/* hdl/bqlp_pkg.sv */
// shared types and constants for the biquad lowpass unit
package bqlp_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int GAIN_W      = 16;
    localparam int GAIN_FRAC   = 15;
    localparam int FF_COEFF_W  = 16;
    localparam int FB_COEFF_W  = 17;
    localparam int SHIFT_W     = 5;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    localparam int HIST_W  = 32;
    localparam int ACC_W   = 64;
    localparam int MUL_A_W = HIST_W + 1;
    localparam int MUL_B_W = FB_COEFF_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SHAMT_W = SHIFT_W + 1;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(16);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FF_COEFF  = 3'd0,
        REG_FF_SHIFT  = 3'd1,
        REG_FB1_COEFF = 3'd2,
        REG_FB1_SHIFT = 3'd3,
        REG_FB2_COEFF = 3'd4,
        REG_FB2_SHIFT = 3'd5
    } cfg_reg_t;

    // positive amount shifts right arithmetic, negative shifts left
    typedef struct packed {
        logic [ACC_W-1:0]          value;
        logic signed [SHAMT_W-1:0] amount;
    } shift_req_t;

endpackage

/* hdl/bqlp_shifter.sv */
// shared bidirectional barrel shifter for the biquad datapath
module bqlp_shifter
(
    input  bqlp_pkg::shift_req_t        req,
    output logic [bqlp_pkg::ACC_W-1:0]  result
);

    logic [bqlp_pkg::SHAMT_W-1:0] left_amt;

    assign left_amt = bqlp_pkg::SHAMT_W'(-req.amount);

    always_comb
    begin
        if (req.amount[bqlp_pkg::SHAMT_W-1])
        begin
            result = req.value << left_amt;
        end
        else
        begin
            result = bqlp_pkg::ACC_W'($signed(req.value) >>> req.amount[bqlp_pkg::SHAMT_W-2:0]);
        end
    end

endmodule

/* hdl/biquad_lowpass_fixed_point_unit.sv */
// top level of the second-order lowpass iir with output gain
//
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//  in      | in_valid / in_ready   | sample_in, gain
//  out     | out_valid / out_ready | sample_out
//
// a taken request runs through mul_ff, mul_fb1, mul_fb2, acc_fb2, scale, gain
// and out before a new one is taken; four of them use one 33x18 multiplier.
// the result waits in an output register; only the last step stalls on out_ready.
// asynchronous reset clears history, coefficients and output; shifts reset to 16.
// cfg_ready is always high; the user must write registers only while the unit is idle; the unit does not enforce it.
module biquad_lowpass_fixed_point_unit
#(
    parameter int SAMPLE_WIDTH = bqlp_pkg::SAMPLE_WIDTH_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [bqlp_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [bqlp_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]         sample_in,
    input  logic signed [bqlp_pkg::GAIN_W-1:0]     gain,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]         sample_out
);

    localparam int SUM_W = SAMPLE_WIDTH + 2;
    localparam int OUT_LO = bqlp_pkg::GAIN_FRAC;
    localparam int OUT_TOP = OUT_LO + SAMPLE_WIDTH - 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_FF,
        ST_MUL_FB1,
        ST_MUL_FB2,
        ST_ACC_FB2,
        ST_SCALE,
        ST_GAIN,
        ST_OUT
    } state_t;

    state_t state_reg;

    logic [bqlp_pkg::FF_COEFF_W-1:0]        ff_coeff_reg;
    logic [bqlp_pkg::SHIFT_W-1:0]           ff_shift_reg;
    logic signed [bqlp_pkg::FB_COEFF_W-1:0] fb1_coeff_reg;
    logic [bqlp_pkg::SHIFT_W-1:0]           fb1_shift_reg;
    logic signed [bqlp_pkg::FB_COEFF_W-1:0] fb2_coeff_reg;
    logic [bqlp_pkg::SHIFT_W-1:0]           fb2_shift_reg;

    logic signed [SAMPLE_WIDTH-1:0]         x1_reg;
    logic signed [SAMPLE_WIDTH-1:0]         x2_reg;
    logic signed [bqlp_pkg::HIST_W-1:0]     y1_reg;
    logic signed [bqlp_pkg::HIST_W-1:0]     y2_reg;

    logic signed [SAMPLE_WIDTH-1:0]         x_reg;
    logic signed [bqlp_pkg::GAIN_W-1:0]     gain_reg;
    logic signed [bqlp_pkg::PROD_W-1:0]     prod_reg;
    logic [bqlp_pkg::ACC_W-1:0]             acc_reg;

    logic                                   out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0]         sample_out_reg;

    logic signed [SUM_W-1:0]                x_ext;
    logic signed [SUM_W-1:0]                x1_ext;
    logic signed [SUM_W-1:0]                x2_ext;
    logic signed [SUM_W-1:0]                ff_sum;
    logic signed [bqlp_pkg::MUL_A_W-1:0]    mul_a;
    logic signed [bqlp_pkg::MUL_B_W-1:0]    mul_b;
    logic signed [bqlp_pkg::PROD_W-1:0]     mul_p;
    logic signed [bqlp_pkg::SHAMT_W-1:0]    fb1_diff;
    logic signed [bqlp_pkg::SHAMT_W-1:0]    fb2_diff;
    bqlp_pkg::shift_req_t                   shift_req;
    logic [bqlp_pkg::ACC_W-1:0]             shift_out;
    logic [bqlp_pkg::ACC_W-1:0]             prod_ext;
    logic [bqlp_pkg::ACC_W-1:0]             acc_next;
    logic signed [bqlp_pkg::HIST_W-1:0]     y_next;
    logic signed [SAMPLE_WIDTH-1:0]         sample_out_next;
    logic                                   y_fits;
    logic                                   out_fits;

    assign cfg_ready  = 1'b1;
    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

    // x + 2*x1 + x2
    assign x_ext  = SUM_W'(x_reg);
    assign x1_ext = SUM_W'(x1_reg);
    assign x2_ext = SUM_W'(x2_reg);
    assign ff_sum = x_ext + $signed({x1_ext[SUM_W-2:0], 1'b0}) + x2_ext;

    assign fb1_diff = $signed({1'b0, fb1_shift_reg}) - $signed({1'b0, ff_shift_reg});
    assign fb2_diff = $signed({1'b0, fb2_shift_reg}) - $signed({1'b0, ff_shift_reg});

    // operand select for the shared multiplier
    always_comb
    begin
        case (state_reg)
            ST_MUL_FF:
            begin
                mul_a = bqlp_pkg::MUL_A_W'(ff_sum);
                mul_b = $signed({2'b00, ff_coeff_reg});
            end
            ST_MUL_FB1:
            begin
                mul_a = bqlp_pkg::MUL_A_W'(y1_reg);
                mul_b = bqlp_pkg::MUL_B_W'(fb1_coeff_reg);
            end
            ST_MUL_FB2:
            begin
                mul_a = bqlp_pkg::MUL_A_W'(y2_reg);
                mul_b = bqlp_pkg::MUL_B_W'(fb2_coeff_reg);
            end
            ST_GAIN:
            begin
                mul_a = bqlp_pkg::MUL_A_W'(y1_reg);
                mul_b = bqlp_pkg::MUL_B_W'(gain_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign prod_ext = bqlp_pkg::ACC_W'(prod_reg);

    // operand select for the shared shifter
    always_comb
    begin
        case (state_reg)
            ST_MUL_FB2:
            begin
                shift_req.value  = prod_ext;
                shift_req.amount = fb1_diff;
            end
            ST_ACC_FB2:
            begin
                shift_req.value  = prod_ext;
                shift_req.amount = fb2_diff;
            end
            ST_SCALE:
            begin
                shift_req.value  = acc_reg;
                shift_req.amount = $signed({1'b0, ff_shift_reg});
            end
            default:
            begin
                shift_req.value  = acc_reg;
                shift_req.amount = '0;
            end
        endcase
    end

    bqlp_shifter u_shifter
    (
        .req    (shift_req),
        .result (shift_out)
    );

    assign acc_next = acc_reg - shift_out;

    // saturate the scaled total to 32 bits
    assign y_fits = (&shift_out[bqlp_pkg::ACC_W-1:bqlp_pkg::HIST_W-1])
                  | ~(|shift_out[bqlp_pkg::ACC_W-1:bqlp_pkg::HIST_W-1]);

    always_comb
    begin
        if (y_fits)
        begin
            y_next = $signed(shift_out[bqlp_pkg::HIST_W-1:0]);
        end
        else if (shift_out[bqlp_pkg::ACC_W-1])
        begin
            y_next = $signed({1'b1, {(bqlp_pkg::HIST_W-1){1'b0}}});
        end
        else
        begin
            y_next = $signed({1'b0, {(bqlp_pkg::HIST_W-1){1'b1}}});
        end
    end

    // gain product >> 15, saturated to the sample width
    assign out_fits = (&prod_reg[bqlp_pkg::PROD_W-1:OUT_TOP])
                    | ~(|prod_reg[bqlp_pkg::PROD_W-1:OUT_TOP]);

    always_comb
    begin
        if (out_fits)
        begin
            sample_out_next = $signed(prod_reg[OUT_TOP:OUT_LO]);
        end
        else if (prod_reg[bqlp_pkg::PROD_W-1])
        begin
            sample_out_next = $signed({1'b1, {(SAMPLE_WIDTH-1){1'b0}}});
        end
        else
        begin
            sample_out_next = $signed({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
        end
    end

    // sequencer, configuration, history and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ff_coeff_reg   <= '0;
            ff_shift_reg   <= bqlp_pkg::SHIFT_RESET;
            fb1_coeff_reg  <= '0;
            fb1_shift_reg  <= bqlp_pkg::SHIFT_RESET;
            fb2_coeff_reg  <= '0;
            fb2_shift_reg  <= bqlp_pkg::SHIFT_RESET;
            x1_reg         <= '0;
            x2_reg         <= '0;
            y1_reg         <= '0;
            y2_reg         <= '0;
            out_valid_reg  <= 1'b0;
            sample_out_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (bqlp_pkg::cfg_reg_t'(cfg_index))
                    bqlp_pkg::REG_FF_COEFF:
                    begin
                        ff_coeff_reg <= cfg_data[bqlp_pkg::FF_COEFF_W-1:0];
                    end
                    bqlp_pkg::REG_FF_SHIFT:
                    begin
                        ff_shift_reg <= cfg_data[bqlp_pkg::SHIFT_W-1:0];
                    end
                    bqlp_pkg::REG_FB1_COEFF:
                    begin
                        fb1_coeff_reg <= $signed(cfg_data[bqlp_pkg::FB_COEFF_W-1:0]);
                    end
                    bqlp_pkg::REG_FB1_SHIFT:
                    begin
                        fb1_shift_reg <= cfg_data[bqlp_pkg::SHIFT_W-1:0];
                    end
                    bqlp_pkg::REG_FB2_COEFF:
                    begin
                        fb2_coeff_reg <= $signed(cfg_data[bqlp_pkg::FB_COEFF_W-1:0]);
                    end
                    bqlp_pkg::REG_FB2_SHIFT:
                    begin
                        fb2_shift_reg <= cfg_data[bqlp_pkg::SHIFT_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            // in the last step a taken result is replaced by the new one below
            if (out_valid_reg && out_ready && state_reg != ST_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_MUL_FF;
                    end
                end
                ST_MUL_FF:
                begin
                    state_reg <= ST_MUL_FB1;
                end
                ST_MUL_FB1:
                begin
                    state_reg <= ST_MUL_FB2;
                end
                ST_MUL_FB2:
                begin
                    state_reg <= ST_ACC_FB2;
                end
                ST_ACC_FB2:
                begin
                    state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    x2_reg    <= x1_reg;
                    x1_reg    <= x_reg;
                    y2_reg    <= y1_reg;
                    y1_reg    <= y_next;
                    state_reg <= ST_GAIN;
                end
                ST_GAIN:
                begin
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    // hold here until the previous result has been taken
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        sample_out_reg <= sample_out_next;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            x_reg    <= sample_in;
            gain_reg <= gain;
        end
        if (state_reg == ST_MUL_FF || state_reg == ST_MUL_FB1
            || state_reg == ST_MUL_FB2 || state_reg == ST_GAIN)
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == ST_MUL_FB1)
        begin
            acc_reg <= prod_ext;
        end
        else if (state_reg == ST_MUL_FB2 || state_reg == ST_ACC_FB2)
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

/* hdl/bqlp_checker.sv */
// port-level checks for the biquad lowpass unit, bound to the top level
module bqlp_checker
#(
    parameter int SAMPLE_WIDTH = bqlp_pkg::SAMPLE_WIDTH_DEF
)
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               cfg_valid,
    input logic                               cfg_ready,
    input logic [bqlp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input logic [bqlp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic [SAMPLE_WIDTH-1:0]            sample_in,
    input logic [bqlp_pkg::GAIN_W-1:0]        gain,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [SAMPLE_WIDTH-1:0]            sample_out
);

    // a waiting result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out))
        else $error("result changed or dropped while stalled");

    // a taken request keeps the unit busy for the following cycles
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("unit ready again too soon after a request");

    // a new result only comes out of a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without work in progress");

    // reset leaves the unit idle with no result pending
    assert property (@(posedge clk)
        !rst_n |=> !out_valid && in_ready)
        else $error("unit not idle during reset");

endmodule

bind biquad_lowpass_fixed_point_unit bqlp_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_bqlp_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .gain       (gain),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out)
);
